FILE: hdl/etfd_pkg.sv
package etfd_pkg;

    // frame layout
    localparam int FRAME_LEN = 22;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] FRAME_LEN_CNT = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] SUM_SPAN      = 5'd18;
    localparam logic [CNT_W-1:0] COUNT_MAX     = 5'd31;

    // byte offsets of the little-endian fields
    localparam int OFS_VOLTS = 0;
    localparam int OFS_THERM = 2;
    localparam int OFS_AMPS  = 4;
    localparam int OFS_RPM   = 8;
    localparam int OFS_THR   = 12;
    localparam int OFS_DUTY  = 14;
    localparam int OFS_FLAGS = 16;
    localparam int OFS_SUM   = 18;
    localparam int OFS_STOP  = 20;

    localparam logic [7:0] STOP_BYTE    = 8'hFF;
    localparam logic [8:0] FLETCHER_MOD = 9'd255;

    // rpm divider
    localparam int DIV_W     = 32;
    localparam int DSR_W     = 8;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] STEPS_FULL = 5'd16;
    localparam logic [DSR_W-1:0]     POLE_RESET = 8'd2;

    // constant divisions as reciprocal multiplies, exact over each operand range
    // current: doubled 16-bit raw value over 25
    localparam int AMPS_SHIFT  = 22;
    localparam int AMPS_PROD_W = 35;
    localparam logic [17:0] AMPS_RECIP = 18'd167773;
    // percentages: 16-bit raw value over 100
    localparam int PCT_SHIFT  = 23;
    localparam int PCT_PROD_W = 33;
    localparam logic [16:0] PCT_RECIP = 17'd83887;
    // power: 29-bit volts times amps over 100
    localparam int PROD_W     = 29;
    localparam int POW_SHIFT  = 36;
    localparam int POW_PROD_W = 59;
    localparam logic [29:0] POW_RECIP = 30'd687194768;

    typedef enum logic [1:0] {
        FS_OK      = 2'd0,
        FS_BAD_LEN = 2'd1,
        FS_NO_STOP = 2'd2,
        FS_BAD_SUM = 2'd3
    } frame_status_t;

    typedef enum logic {
        CFG_POLE = 1'b0,
        CFG_CHK  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic scale;
        logic mul;
        logic pow;
        logic div_store;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_ok;
        logic div_done;
    } dp_status_t;

endpackage

FILE: hdl/etfd_div.sv
module etfd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [etfd_pkg::DIV_W-1:0]     dividend,
    input  logic [etfd_pkg::DSR_W-1:0]     divisor,
    input  logic [etfd_pkg::DIV_CNT_W-1:0] steps,
    output logic                           done,
    output logic [etfd_pkg::DIV_W-1:0]     quotient
);
    import etfd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     dsr_reg;

    logic [DSR_W:0]   t1, t2;
    logic             ge1, ge2;
    logic [DSR_W-1:0] r1, r2;
    logic [DIV_W-1:0] d1, d2;

    // two restoring steps per cycle
    always_comb
    begin
        t1  = {rem_reg, dvd_reg[DIV_W-1]};
        ge1 = (t1 >= {1'b0, dsr_reg});
        r1  = ge1 ? DSR_W'(t1 - {1'b0, dsr_reg}) : t1[DSR_W-1:0];
        d1  = {dvd_reg[DIV_W-2:0], ge1};
        t2  = {r1, d1[DIV_W-1]};
        ge2 = (t2 >= {1'b0, dsr_reg});
        r2  = ge2 ? DSR_W'(t2 - {1'b0, dsr_reg}) : t2[DSR_W-1:0];
        d2  = {d1[DIV_W-2:0], ge2};
    end

    // step counter
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2;
            dvd_reg <= d2;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: hdl/etfd_dp.sv
module etfd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  etfd_pkg::cfg_index_t cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [7:0]           rx_byte,
    input  etfd_pkg::dp_cmd_t    cmd,
    output etfd_pkg::dp_status_t status,
    output logic [1:0]           frame_status,
    output logic [15:0]          volts_centi,
    output logic [12:0]          amps_in,
    output logic [31:0]          shaft_rpm,
    output logic [9:0]           throttle_pct,
    output logic [9:0]           motor_duty_pct,
    output logic [21:0]          power_in,
    output logic [15:0]          thermistor_raw,
    output logic [7:0]           esc_flags
);
    import etfd_pkg::*;

    logic [DSR_W-1:0] pole_reg;
    logic             chk_en_reg;
    logic [CNT_W-1:0] byte_cnt_reg;
    logic [7:0]       sum_lo_reg, sum_hi_reg;
    logic [7:0]       store_reg [FRAME_LEN];

    logic [8:0]  s_lo9, s_hi9;
    logic [7:0]  sum_lo_new, sum_hi_new;

    logic [15:0] volts_w, therm_w, amps_w, thr_w, duty_w, chk_w;
    logic [31:0] erpm_w;
    logic [DSR_W-1:0] pole_eff;

    frame_status_t status_next, status_reg;

    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    logic [AMPS_PROD_W-1:0] amps_prod;
    logic [PCT_PROD_W-1:0]  thr_prod, duty_prod;
    logic [POW_PROD_W-1:0]  pow_prod;

    logic [12:0]       amps_q_reg;
    logic [21:0]       pow_q_reg;
    logic [9:0]        thr_q_reg, duty_q_reg;
    logic [31:0]       rpm_q_reg;
    logic [PROD_W-1:0] prod_reg;

    frame_status_t out_status_reg;
    logic [15:0]   out_volts_reg, out_therm_reg;
    logic [12:0]   out_amps_reg;
    logic [31:0]   out_rpm_reg;
    logic [9:0]    out_thr_reg, out_duty_reg;
    logic [21:0]   out_pow_reg;
    logic [7:0]    out_flags_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg   <= POLE_RESET;
            chk_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLE: pole_reg   <= cfg_data;
                CFG_CHK:  chk_en_reg <= cfg_data[0];
            endcase
        end
    end

    // fletcher-16 sums, modulo 255
    always_comb
    begin
        s_lo9      = {1'b0, sum_lo_reg} + {1'b0, rx_byte};
        sum_lo_new = (s_lo9 >= FLETCHER_MOD) ? 8'(s_lo9 - FLETCHER_MOD) : s_lo9[7:0];
        s_hi9      = {1'b0, sum_hi_reg} + {1'b0, sum_lo_new};
        sum_hi_new = (s_hi9 >= FLETCHER_MOD) ? 8'(s_hi9 - FLETCHER_MOD) : s_hi9[7:0];
    end

    // byte count and sums, cleared once the frame is checked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            sum_lo_reg   <= '0;
            sum_hi_reg   <= '0;
        end
        else if (cmd.capture)
        begin
            if (byte_cnt_reg < SUM_SPAN)
            begin
                sum_lo_reg <= sum_lo_new;
                sum_hi_reg <= sum_hi_new;
            end
            if (byte_cnt_reg != COUNT_MAX)
                byte_cnt_reg <= byte_cnt_reg + CNT_W'(1);
        end
        else if (cmd.eval)
        begin
            byte_cnt_reg <= '0;
            sum_lo_reg   <= '0;
            sum_hi_reg   <= '0;
        end
    end

    // frame bytes, overlong tail dropped
    always_ff @(posedge clk)
    begin
        if (cmd.capture && (byte_cnt_reg < FRAME_LEN_CNT))
            store_reg[byte_cnt_reg] <= rx_byte;
    end

    // field views
    assign volts_w = {store_reg[OFS_VOLTS+1], store_reg[OFS_VOLTS]};
    assign therm_w = {store_reg[OFS_THERM+1], store_reg[OFS_THERM]};
    assign amps_w  = {store_reg[OFS_AMPS+1], store_reg[OFS_AMPS]};
    assign erpm_w  = {store_reg[OFS_RPM+3], store_reg[OFS_RPM+2],
                      store_reg[OFS_RPM+1], store_reg[OFS_RPM]};
    assign thr_w   = {store_reg[OFS_THR+1], store_reg[OFS_THR]};
    assign duty_w  = {store_reg[OFS_DUTY+1], store_reg[OFS_DUTY]};
    assign chk_w   = {store_reg[OFS_SUM+1], store_reg[OFS_SUM]};
    assign pole_eff = (pole_reg == '0) ? DSR_W'(1) : pole_reg;

    // frame check: length, then stop bytes, then checksum when enabled
    always_comb
    begin
        priority if (byte_cnt_reg != FRAME_LEN_CNT)
            status_next = FS_BAD_LEN;
        else if ((store_reg[OFS_STOP] != STOP_BYTE) || (store_reg[OFS_STOP+1] != STOP_BYTE))
            status_next = FS_NO_STOP;
        else if (chk_en_reg && ({sum_hi_reg, sum_lo_reg} != chk_w))
            status_next = FS_BAD_SUM;
        else
            status_next = FS_OK;
    end

    assign status.frame_ok = (status_next == FS_OK);
    assign status.div_done = div_done;

    // constant divisions: multiply by the reciprocal, keep the high bits
    always_comb
    begin
        amps_prod = AMPS_PROD_W'({amps_w, 1'b0}) * AMPS_PROD_W'(AMPS_RECIP);
        thr_prod  = PCT_PROD_W'(thr_w) * PCT_PROD_W'(PCT_RECIP);
        duty_prod = PCT_PROD_W'(duty_w) * PCT_PROD_W'(PCT_RECIP);
        pow_prod  = POW_PROD_W'(prod_reg) * POW_PROD_W'(POW_RECIP);
    end

    // rpm division starts together with the constant scaling
    etfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.scale),
        .dividend (erpm_w),
        .divisor  (pole_eff),
        .steps    (STEPS_FULL),
        .done     (div_done),
        .quotient (div_quot)
    );

    // status, product and quotients
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
            status_reg <= status_next;
        if (cmd.scale)
        begin
            amps_q_reg <= amps_prod[AMPS_SHIFT +: 13];
            thr_q_reg  <= thr_prod[PCT_SHIFT +: 10];
            duty_q_reg <= duty_prod[PCT_SHIFT +: 10];
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(volts_w) * PROD_W'(amps_q_reg);
        if (cmd.pow)
            pow_q_reg <= pow_prod[POW_SHIFT +: 22];
        if (cmd.div_store)
            rpm_q_reg <= div_quot;
    end

    // output register, fields zeroed on a rejected frame
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            if (status_reg == FS_OK)
            begin
                out_volts_reg <= volts_w;
                out_amps_reg  <= amps_q_reg;
                out_rpm_reg   <= rpm_q_reg;
                out_thr_reg   <= thr_q_reg;
                out_duty_reg  <= duty_q_reg;
                out_pow_reg   <= pow_q_reg;
                out_therm_reg <= therm_w;
                out_flags_reg <= store_reg[OFS_FLAGS];
            end
            else
            begin
                out_volts_reg <= '0;
                out_amps_reg  <= '0;
                out_rpm_reg   <= '0;
                out_thr_reg   <= '0;
                out_duty_reg  <= '0;
                out_pow_reg   <= '0;
                out_therm_reg <= '0;
                out_flags_reg <= '0;
            end
        end
    end

    assign frame_status   = out_status_reg;
    assign volts_centi    = out_volts_reg;
    assign amps_in        = out_amps_reg;
    assign shaft_rpm      = out_rpm_reg;
    assign throttle_pct   = out_thr_reg;
    assign motor_duty_pct = out_duty_reg;
    assign power_in       = out_pow_reg;
    assign thermistor_raw = out_therm_reg;
    assign esc_flags      = out_flags_reg;

endmodule

FILE: hdl/etfd_ctrl.sv
module etfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 frame_end,
    output logic                 in_stall,
    input  logic                 out_stall,
    output logic                 out_valid,
    input  etfd_pkg::dp_status_t status,
    output etfd_pkg::dp_cmd_t    cmd
);
    import etfd_pkg::*;

    typedef enum logic [6:0] {
        ST_RX    = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_SCALE = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_POW   = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_LOAD  = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;

    // sequencing: receive, check, scale and divide (skipped for a rejected frame), hand result to the output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_RX:
            begin
                cmd.capture = in_valid;
                if (in_valid && frame_end)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.frame_ok)
                    state_next = ST_SCALE;
                else
                    state_next = ST_LOAD;
            end
            ST_SCALE:
            begin
                // current and percentages, rpm division starts
                cmd.scale  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_POW;
            end
            ST_POW:
            begin
                cmd.pow    = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_RX;
                end
            end
            default:
                state_next = ST_RX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_RX);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/esc_telemetry_frame_decoder.sv
// bytes are taken one per cycle while a frame arrives
// after the last byte the frame is checked; a rejected result goes on to the output load,
// a good one is scaled first and waits for the rpm divider (2 quotient bits a cycle)
// intake stalls from the last byte of a frame until its result is loaded
// the next frame is taken while a result waits; a stalled result holds the next load
// rst_n clears count, sums, control and configuration; the frame store is not cleared
module esc_telemetry_frame_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  etfd_pkg::cfg_index_t cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           frame_status,
    output logic [15:0]          volts_centi,
    output logic [12:0]          amps_in,
    output logic [31:0]          shaft_rpm,
    output logic [9:0]           throttle_pct,
    output logic [9:0]           motor_duty_pct,
    output logic [21:0]          power_in,
    output logic [15:0]          thermistor_raw,
    output logic [7:0]           esc_flags
);
    import etfd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    etfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    etfd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .frame_status   (frame_status),
        .volts_centi    (volts_centi),
        .amps_in        (amps_in),
        .shaft_rpm      (shaft_rpm),
        .throttle_pct   (throttle_pct),
        .motor_duty_pct (motor_duty_pct),
        .power_in       (power_in),
        .thermistor_raw (thermistor_raw),
        .esc_flags      (esc_flags)
    );

    // last byte of a frame stops intake for the check
    a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && frame_end) |=> in_stall)
        else $error("intake not stalled after frame end");

    // loading the output register presents a result
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("result not presented after load");

    // rejected frames carry zero volts, rpm, power and flags
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (frame_status != FS_OK)) |->
        (volts_centi == '0 && shaft_rpm == '0 && power_in == '0 && esc_flags == '0))
        else $error("rejected frame with nonzero fields");

endmodule
